@@ design/linear_interp_resampler_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the linear interpolation resampler
// Concurrent checks that are clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LIR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/lir_pkg.sv @@
// ----------------------------------------------------------------------------
// Linear interpolation resampler package
// Widths, fixed-point constants and shared types of the resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 24;
  localparam int STEP_BITS   = 32;
  localparam int PHASE_BITS  = STEP_BITS + 1;
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int DIGIT_BITS  = 4;
  localparam int NUM_DIGITS  = FRAC_BITS / DIGIT_BITS;
  localparam int CNT_BITS    = $clog2(NUM_DIGITS);

  localparam logic [PHASE_BITS-1:0] ONE_POS  = PHASE_BITS'(1) << FRAC_BITS;
  localparam logic [PHASE_BITS:0]   TWO_POS  = (PHASE_BITS + 1)'(1) << (FRAC_BITS + 1);
  localparam logic [STEP_BITS-1:0]  MIN_STEP = STEP_BITS'(1) << (FRAC_BITS - 5);
  localparam logic [STEP_BITS-1:0]  RATE_STEP_RESET = STEP_BITS'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LERP,
    S_MUL,
    S_PUSH,
    S_REP
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] a;
    logic signed [DIFF_BITS-1:0]   d;
    logic [FRAC_BITS-1:0]          frac;
  } mul_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          run_end;
    logic                          stream_end;
  } out_word_t;

endpackage

@@ design/lir_channels.sv @@
// ----------------------------------------------------------------------------
// Linear interpolation resampler channels
// Valid/ready interfaces for the input, output and configuration words.
// ----------------------------------------------------------------------------
interface lir_in_if import lir_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          in_last;

  modport source (output valid, in_sample, in_last, input ready);
  modport sink (input valid, in_sample, in_last, output ready);
endinterface

interface lir_out_if import lir_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          run_end;
  logic                          stream_end;

  modport source (output valid, out_sample, run_end, stream_end, input ready);
  modport sink (input valid, out_sample, run_end, stream_end, output ready);
endinterface

interface lir_cfg_if import lir_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STEP_BITS-1:0] rate_step;

  modport source (output valid, rate_step, input ready);
  modport sink (input valid, rate_step, output ready);
endinterface

@@ design/lir_serial_mult.sv @@
// ----------------------------------------------------------------------------
// Digit-serial interpolation multiplier
// Computes a + round(d * frac), one 4-bit digit of frac per cycle.
// ----------------------------------------------------------------------------
`include "linear_interp_resampler_macros.svh"

module lir_serial_mult import lir_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  mul_req_t                      req,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int PROD_BITS = DIFF_BITS + DIGIT_BITS + 1;
  localparam int SUM_BITS  = DIFF_BITS + 1;

  logic                          busy;
  logic [CNT_BITS-1:0]           cnt;
  logic signed [SAMPLE_BITS-1:0] a_r;
  logic signed [DIFF_BITS-1:0]   d_r;
  logic [FRAC_BITS-1:0]          fsh;
  logic signed [DIFF_BITS-1:0]   hi;
  logic                          rnd;

  logic [DIGIT_BITS-1:0]         digit;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [PROD_BITS-1:0]   acc;
  logic                          last_digit;
  logic [SUM_BITS-1:0]           sum;

  always_comb begin
    digit      = fsh[DIGIT_BITS-1:0];
    prod       = PROD_BITS'(d_r) * PROD_BITS'($signed({1'b0, digit}));
    acc        = prod + PROD_BITS'(hi);
    last_digit = (cnt == CNT_BITS'(NUM_DIGITS - 1));
    sum        = SUM_BITS'(a_r) + SUM_BITS'(hi) + SUM_BITS'(rnd);
  end

  assign result = sum[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last_digit;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_BITS'(1);
        if (last_digit) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= req.a;
      d_r <= req.d;
      fsh <= req.frac;
      hi  <= '0;
      rnd <= 1'b0;
    end else if (busy) begin
      fsh <= fsh >> DIGIT_BITS;
      hi  <= acc[DIFF_BITS+DIGIT_BITS-1:DIGIT_BITS];
      rnd <= acc[DIGIT_BITS-1];
    end
  end

  `LIR_ASSERT_NOW(a_start_idle, start, !busy && !done, "Multiplier restarted while busy.")
  `LIR_ASSERT_NEXT(a_done_after_last, busy && last_digit, done && !busy,
                   "Multiplier did not finish after its last digit.")

endmodule

@@ design/lir_out_reg.sv @@
// ----------------------------------------------------------------------------
// Output register
// Holds one result word so the sequencer can run on while the receiver stalls.
// ----------------------------------------------------------------------------
`include "linear_interp_resampler_macros.svh"

module lir_out_reg import lir_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  out_word_t  word,
  output logic       space,
  lir_out_if.source  dst
);

  logic      vld;
  out_word_t data;

  assign space          = !vld || dst.ready;
  assign dst.valid      = vld;
  assign dst.out_sample = data.out_sample;
  assign dst.run_end    = data.run_end;
  assign dst.stream_end = data.stream_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (push) begin
      vld <= 1'b1;
    end else if (dst.ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= word;
    end
  end

  `LIR_ASSERT_NOW(a_no_overwrite, push, !vld || dst.ready,
                  "A held output word was overwritten.")

endmodule

@@ design/linear_interp_resampler.sv @@
// ----------------------------------------------------------------------------
// Linear interpolation resampler
// Converts a mono sample stream to a new rate by linear interpolation.
// ----------------------------------------------------------------------------
// Input words (src) carry one signed sample and a last flag. Output words
// (dst) carry one interpolated sample, run_end on the last word caused by an
// input word, and stream_end on the final word of the stream. The cfg channel
// writes rate_step (source over target rate, unsigned Q8.24) and is always
// ready; rate_step must be written only between input words while the block
// is idle, and the block itself does not enforce this. An input word is
// taken only when the previous one is fully worked off. Each interpolated
// output comes from the digit-serial multiplier, which handles 4 bits of the
// phase fraction per cycle. An output that repeats the final sample bypasses
// the multiplier. The first sample of a stream is only stored, unless it is
// also its last. Reset returns rate_step to 1.0, clears the phase and drops
// the stored sample. A stalled receiver holds the output register and the
// sequencer waits until the word is taken.
// ----------------------------------------------------------------------------
`include "linear_interp_resampler_macros.svh"

module linear_interp_resampler import lir_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lir_cfg_if.sink   cfg,
  lir_in_if.sink    src,
  lir_out_if.source dst
);

  state_t                        state;
  state_t                        state_next;
  logic [STEP_BITS-1:0]          rate_step;
  logic [PHASE_BITS-1:0]         phase;
  logic signed [SAMPLE_BITS-1:0] prev;
  logic signed [SAMPLE_BITS-1:0] cur;
  logic                          last;
  logic                          have_prev;
  logic                          rep;
  logic signed [SAMPLE_BITS-1:0] res;

  logic [STEP_BITS-1:0]          step_eff;
  logic [PHASE_BITS-1:0]         phase_add;
  logic                          phase_lt_one;
  logic                          ge_one;
  logic                          ge_two;
  logic                          fin;
  logic                          accept;
  logic                          mul_start;
  logic                          mul_done;
  logic signed [SAMPLE_BITS-1:0] mul_res;
  mul_req_t                      mul_req;
  logic                          push;
  logic                          out_space;
  out_word_t                     word;

  assign cfg.ready = 1'b1;
  assign accept    = src.valid && src.ready;

  always_comb begin
    step_eff     = (rate_step < MIN_STEP) ? MIN_STEP : rate_step;
    phase_add    = phase + PHASE_BITS'(step_eff);
    phase_lt_one = (phase < ONE_POS);
    ge_one       = (phase_add >= ONE_POS);
    ge_two       = ({1'b0, phase_add} >= TWO_POS);
    fin          = last ? (rep ? ge_one : ge_two) : ge_one;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (src.valid) begin
          if (have_prev) begin
            state_next = S_LERP;
          end else if (src.in_last) begin
            state_next = S_REP;
          end
        end
      end
      S_LERP: begin
        if (phase_lt_one) begin
          state_next = S_MUL;
        end else if (last) begin
          state_next = S_REP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_space) begin
          state_next = rep ? S_REP : S_LERP;
        end
      end
      S_REP: begin
        state_next = phase_lt_one ? S_PUSH : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    src.ready         = (state == S_IDLE);
    mul_start         = (state == S_LERP) && phase_lt_one;
    push              = (state == S_PUSH) && out_space;
    mul_req.a         = prev;
    mul_req.d         = $signed({cur[SAMPLE_BITS-1], cur}) - $signed({prev[SAMPLE_BITS-1], prev});
    mul_req.frac      = phase[FRAC_BITS-1:0];
    word.out_sample   = res;
    word.run_end      = fin;
    word.stream_end   = fin && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rate_step <= RATE_STEP_RESET;
      phase     <= '0;
      have_prev <= 1'b0;
      rep       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        rate_step <= cfg.rate_step;
      end
      if (accept && !have_prev && !src.in_last) begin
        have_prev <= 1'b1;
      end
      if ((state == S_LERP) && !phase_lt_one) begin
        phase <= phase - ONE_POS;
      end
      if (state == S_MUL) begin
        rep <= 1'b0;
      end
      if (state == S_REP) begin
        if (phase_lt_one) begin
          rep <= 1'b1;
        end else begin
          have_prev <= 1'b0;
          phase     <= '0;
          rep       <= 1'b0;
        end
      end
      if (push) begin
        phase <= phase_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur  <= src.in_sample;
      last <= src.in_last;
      if (!have_prev) begin
        prev <= src.in_sample;
      end
    end
    if ((state == S_LERP) && !phase_lt_one) begin
      prev <= cur;
    end
    if ((state == S_MUL) && mul_done) begin
      res <= mul_res;
    end
    if ((state == S_REP) && phase_lt_one) begin
      res <= cur;
    end
  end

  lir_serial_mult u_mult (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .req    (mul_req),
    .done   (mul_done),
    .result (mul_res)
  );

  lir_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .word  (word),
    .space (out_space),
    .dst   (dst)
  );

  `LIR_ASSERT_NOW(a_phase_in_span, state == S_MUL || state == S_PUSH, phase < ONE_POS,
                  "Output started with the phase past the current sample.")
  `LIR_ASSERT_NOW(a_fresh_phase, state == S_IDLE && !have_prev, phase == '0,
                  "Phase is not cleared at the start of a stream.")
  `LIR_ASSERT_NOW(a_stream_end_run_end, dst.valid && dst.stream_end, dst.run_end,
                  "Final word of the stream does not close its run.")

endmodule
